// ===== rtl/dasc_pkg.sv =====
// shared constants, item types and control structs for the decimal add/sub/compare block
package dasc_pkg;

    localparam int DIGITS    = 32;
    localparam int IDX_W     = $clog2(DIGITS);
    localparam int CNT_W     = $clog2(DIGITS + 1);
    localparam int DIG_W     = 4;
    localparam int RADIX     = 10;
    localparam int MAX_DIGIT = 9;

    localparam logic [1:0] CMP_LT = 2'd0;
    localparam logic [1:0] CMP_EQ = 2'd1;
    localparam logic [1:0] CMP_GT = 2'd2;

    localparam logic OP_ADD = 1'b0;
    localparam logic OP_SUB = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [DIG_W-1:0] digit_a;
        logic [DIG_W-1:0] digit_b;
        logic             last;
    } t_in;

    typedef struct packed {
        logic [DIG_W-1:0] digit;
        logic             negative;
        logic [1:0]       compare;
        logic             overflow;
        logic             last_digit;
    } t_out;

    typedef struct packed {
        logic load;
        logic issue;
        logic carry;
        logic put;
    } t_cmd;

    typedef struct packed {
        logic iss_last;
        logic top_zero;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/dasc_dp.sv =====
// datapath: operand and result memories, digit-serial add/subtract, running compare, output register
module dasc_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  dasc_pkg::t_cmd  i_cmd,
    input  dasc_pkg::t_in   i_in_item,
    input  logic            i_out_stall,
    output dasc_pkg::t_sts  o_sts,
    output logic            o_out_valid,
    output dasc_pkg::t_out  o_out_item
);

    logic [dasc_pkg::DIG_W-1:0] mem_a [dasc_pkg::DIGITS];
    logic [dasc_pkg::DIG_W-1:0] mem_b [dasc_pkg::DIGITS];
    logic [dasc_pkg::DIG_W-1:0] mem_r [dasc_pkg::DIGITS + 1];

    logic [dasc_pkg::CNT_W-1:0] r_cnt;
    logic                       r_ovf;
    logic [1:0]                 r_cmp;
    logic                       r_op;
    logic [dasc_pkg::CNT_W-1:0] r_iss;
    logic                       r_cv;
    logic [dasc_pkg::CNT_W-1:0] r_widx;
    logic                       r_carry;
    logic [dasc_pkg::CNT_W-1:0] r_top;
    logic [dasc_pkg::DIG_W-1:0] r_rd_a;
    logic [dasc_pkg::DIG_W-1:0] r_rd_b;
    logic [dasc_pkg::DIG_W-1:0] r_rd_r;
    logic                       r_out_valid;
    dasc_pkg::t_out             r_out;

    logic [dasc_pkg::DIG_W-1:0] a_cl;
    logic [dasc_pkg::DIG_W-1:0] b_cl;
    logic                       full;
    logic                       wr_en;
    logic                       swap;
    logic [dasc_pkg::DIG_W-1:0] big;
    logic [dasc_pkg::DIG_W-1:0] small_d;
    logic [dasc_pkg::DIG_W:0]   sum5;
    logic                       sum_ge;
    logic [dasc_pkg::DIG_W:0]   sub_part;
    logic                       borrow;
    logic [dasc_pkg::DIG_W-1:0] add_d;
    logic [dasc_pkg::DIG_W-1:0] sub_d;
    logic [dasc_pkg::DIG_W-1:0] res_d;
    logic                       res_c;
    logic                       carry_we;
    logic                       res_we;
    logic [dasc_pkg::DIG_W-1:0] res_wdata;

    // clamp input digits
    assign a_cl = (i_in_item.digit_a > dasc_pkg::DIG_W'(dasc_pkg::MAX_DIGIT))
                ? dasc_pkg::DIG_W'(dasc_pkg::MAX_DIGIT) : i_in_item.digit_a;
    assign b_cl = (i_in_item.digit_b > dasc_pkg::DIG_W'(dasc_pkg::MAX_DIGIT))
                ? dasc_pkg::DIG_W'(dasc_pkg::MAX_DIGIT) : i_in_item.digit_b;

    assign full  = (r_cnt == dasc_pkg::CNT_W'(dasc_pkg::DIGITS));
    assign wr_en = i_cmd.load && !full;

    // digit stage
    assign swap    = (r_cmp == dasc_pkg::CMP_LT);
    assign big     = swap ? r_rd_b : r_rd_a;
    assign small_d = swap ? r_rd_a : r_rd_b;

    assign sum5   = {1'b0, r_rd_a} + {1'b0, r_rd_b} + {{dasc_pkg::DIG_W{1'b0}}, r_carry};
    assign sum_ge = (sum5 >= (dasc_pkg::DIG_W + 1)'(dasc_pkg::RADIX));
    assign add_d  = sum_ge ? dasc_pkg::DIG_W'(sum5 - (dasc_pkg::DIG_W + 1)'(dasc_pkg::RADIX))
                           : sum5[dasc_pkg::DIG_W-1:0];

    assign sub_part = {1'b0, small_d} + {{dasc_pkg::DIG_W{1'b0}}, r_carry};
    assign borrow   = ({1'b0, big} < sub_part);
    assign sub_d    = borrow
        ? dasc_pkg::DIG_W'({1'b0, big} + (dasc_pkg::DIG_W + 1)'(dasc_pkg::RADIX) - sub_part)
        : dasc_pkg::DIG_W'({1'b0, big} - sub_part);

    assign res_d = (r_op == dasc_pkg::OP_SUB) ? sub_d : add_d;
    assign res_c = (r_op == dasc_pkg::OP_SUB) ? borrow : sum_ge;

    // extra leading one after an addition carry
    assign carry_we  = i_cmd.carry && (r_op == dasc_pkg::OP_ADD) && r_carry;
    assign res_we    = r_cv || carry_we;
    assign res_wdata = r_cv ? res_d : dasc_pkg::DIG_W'(1);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_a[r_cnt[dasc_pkg::IDX_W-1:0]] <= a_cl;
            mem_b[r_cnt[dasc_pkg::IDX_W-1:0]] <= b_cl;
        end
        r_rd_a <= mem_a[r_iss[dasc_pkg::IDX_W-1:0]];
        r_rd_b <= mem_b[r_iss[dasc_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (res_we) begin
            mem_r[r_widx] <= res_wdata;
        end
        r_rd_r <= mem_r[r_top];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_ovf       <= 1'b0;
            r_cmp       <= dasc_pkg::CMP_EQ;
            r_op        <= dasc_pkg::OP_ADD;
            r_iss       <= '0;
            r_cv        <= 1'b0;
            r_widx      <= '0;
            r_carry     <= 1'b0;
            r_top       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_cv <= i_cmd.issue;
            if (i_cmd.load) begin
                if (!full) begin
                    r_cnt <= r_cnt + dasc_pkg::CNT_W'(1);
                    if (a_cl > b_cl) begin
                        r_cmp <= dasc_pkg::CMP_GT;
                    end else if (a_cl < b_cl) begin
                        r_cmp <= dasc_pkg::CMP_LT;
                    end
                end else begin
                    r_ovf <= 1'b1;
                end
                if (i_in_item.last) begin
                    r_op <= i_in_item.operation;
                end
                r_iss   <= '0;
                r_widx  <= '0;
                r_carry <= 1'b0;
                r_top   <= '0;
            end
            if (i_cmd.issue) begin
                r_iss <= r_iss + dasc_pkg::CNT_W'(1);
            end
            if (r_cv) begin
                r_widx  <= r_widx + dasc_pkg::CNT_W'(1);
                r_carry <= res_c;
                if (res_d != '0) begin
                    r_top <= r_widx;
                end
            end
            if (carry_we) begin
                r_top <= r_widx;
            end
            if (i_cmd.put) begin
                r_out_valid <= 1'b1;
                if (r_top == '0) begin
                    r_cnt <= '0;
                    r_ovf <= 1'b0;
                    r_cmp <= dasc_pkg::CMP_EQ;
                end else begin
                    r_top <= r_top - dasc_pkg::CNT_W'(1);
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.put) begin
            r_out.digit      <= r_rd_r;
            r_out.negative   <= (r_op == dasc_pkg::OP_SUB) && swap;
            r_out.compare    <= r_cmp;
            r_out.overflow   <= r_ovf;
            r_out.last_digit <= (r_top == '0);
        end
    end

    assign o_sts.iss_last = (r_iss == (r_cnt - dasc_pkg::CNT_W'(1)));
    assign o_sts.top_zero = (r_top == '0);
    assign o_sts.out_free = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

// ===== rtl/dasc_ctrl.sv =====
// controller: sequences load, digit pass, carry fixup and result emission
module dasc_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_last,
    input  dasc_pkg::t_sts  i_sts,
    output logic            o_in_stall,
    output dasc_pkg::t_cmd  o_cmd
);

    // emission alternates read and put; tracked as a sixth state
    typedef enum logic [5:0] {
        S_LOAD    = 6'b000001,
        S_CALC    = 6'b000010,
        S_FINISH  = 6'b000100,
        S_CARRY   = 6'b001000,
        S_EMIT_RD = 6'b010000,
        S_EMIT_PT = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        o_in_stall    = 1'b1;
        case (r_state)
            S_LOAD: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
                if (i_in_valid && i_last) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                o_cmd.issue = 1'b1;
                if (i_sts.iss_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_state = S_CARRY;
            end
            S_CARRY: begin
                o_cmd.carry = 1'b1;
                n_state     = S_EMIT_RD;
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_PT;
            end
            S_EMIT_PT: begin
                if (i_sts.out_free) begin
                    o_cmd.put = 1'b1;
                    n_state   = i_sts.top_zero ? S_LOAD : S_EMIT_RD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/decimal_add_sub_compare.sv =====
// top level of the decimal add/subtract/compare block
// sequence: after the item with last is taken, the stored digit pairs are issued, then come the
//   finish, the carry fixup, the result read and the put into the output register
// throughput: one digit pair per cycle while loading; each result item needs a registered read
//   of the result memory before it is put, and a stalled output holds the put
// reset: synchronous active low; clears the controller, digit count, flags and output valid
module decimal_add_sub_compare (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  dasc_pkg::t_in   i_in_item,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output dasc_pkg::t_out  o_out_item
);

    dasc_pkg::t_cmd cmd;
    dasc_pkg::t_sts sts;

    dasc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last     (i_in_item.last),
        .i_sts      (sts),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd)
    );

    dasc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== rtl/dasc_chk.sv =====
// port-level checker for the decimal add/subtract/compare block, bound to the top level
module dasc_chk (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input dasc_pkg::t_in   i_in_item,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input dasc_pkg::t_out  o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("stalled result item changed");

    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_item.digit < dasc_pkg::DIG_W'(dasc_pkg::RADIX))
        else $error("result digit above nine");

    a_neg_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.negative |-> o_out_item.compare == dasc_pkg::CMP_LT)
        else $error("negative result without a less-than compare");

    a_flags_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_stall && !o_out_item.last_digit ##1 o_out_valid
        |-> o_out_item.compare == $past(o_out_item.compare)
            && o_out_item.overflow == $past(o_out_item.overflow))
        else $error("flags changed within one run");

    a_last_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_in_item.last |=> o_in_stall)
        else $error("input taken while a run is being computed");

endmodule

bind decimal_add_sub_compare dasc_chk u_dasc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
